// File: hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and codes of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_CMP  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // control that travels beside the data of every stage
  typedef struct packed {
    logic       valid;
    logic [2:0] op;
    logic       eq;
    logic       div0;
  } ctl_t;

endpackage

// File: hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// products, sums and divider set-up over three register stages
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  parameter int XW         = 3 * DATA_WIDTH + FRAC_BITS + 1,
  parameter int PASS_W     = 4 + 2 * (2 * DATA_WIDTH + 1) + 2 * (DATA_WIDTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [2:0]                   in_op,
  input  logic signed [DATA_WIDTH-1:0] a_real,
  input  logic signed [DATA_WIDTH-1:0] a_imag,
  input  logic signed [DATA_WIDTH-1:0] b_real,
  input  logic signed [DATA_WIDTH-1:0] b_imag,
  output cau_pkg::ctl_t                ctl_o,
  output logic [XW-1:0]                rem_r,
  output logic [XW-1:0]                rem_i,
  output logic [2*DATA_WIDTH-1:0]      den,
  output logic [PASS_W-1:0]            pass
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W + 1;

  // stage a
  ctl_t                ctl_a;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;
  logic signed [W:0]    s_r, s_r_next, s_i, s_i_next;
  // stage b
  ctl_t                ctl_b;
  logic                neg_r, neg_i;
  logic [MW-1:0]       mag_r, mag_i;
  logic [PW-1:0]       den_b;
  logic signed [W:0]   sb_r, sb_i;
  logic signed [MW-1:0] num_r, num_i;
  // stage c
  ctl_t                ctl_c;

  always_comb begin
    s_r_next = '0;
    s_i_next = '0;
    unique case (in_op)
      OP_ADD: begin
        s_r_next = (W+1)'(a_real) + (W+1)'(b_real);
        s_i_next = (W+1)'(a_imag) + (W+1)'(b_imag);
      end
      OP_SUB: begin
        s_r_next = (W+1)'(a_real) - (W+1)'(b_real);
        s_i_next = (W+1)'(a_imag) - (W+1)'(b_imag);
      end
      OP_CONJ: begin
        s_r_next = (W+1)'(a_real);
        s_i_next = -((W+1)'(a_imag));
      end
      default: begin
        s_r_next = '0;
        s_i_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else if (adv) begin
      ctl_a.valid <= in_valid;
    end
    if (adv) begin
      ctl_a.op   <= in_op;
      ctl_a.eq   <= (in_op == OP_CMP) && (a_real == b_real) && (a_imag == b_imag);
      ctl_a.div0 <= (in_op == OP_DIV) && (b_real == '0) && (b_imag == '0);
      p_rr   <= a_real * b_real;
      p_ii   <= a_imag * b_imag;
      p_ri   <= a_real * b_imag;
      p_ir   <= a_imag * b_real;
      p_bb_r <= b_real * b_real;
      p_bb_i <= b_imag * b_imag;
      s_r    <= s_r_next;
      s_i    <= s_i_next;
    end
  end

  // numerators: product for multiply, textbook form for divide
  always_comb begin
    if (ctl_a.op == OP_MUL) begin
      num_r = MW'(p_rr) - MW'(p_ii);
      num_i = MW'(p_ri) + MW'(p_ir);
    end else begin
      num_r = MW'(p_rr) + MW'(p_ii);
      num_i = MW'(p_ir) - MW'(p_ri);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b.valid <= 1'b0;
    end else if (adv) begin
      ctl_b.valid <= ctl_a.valid;
    end
    if (adv) begin
      ctl_b.op   <= ctl_a.op;
      ctl_b.eq   <= ctl_a.eq;
      ctl_b.div0 <= ctl_a.div0;
      neg_r <= num_r[MW-1];
      neg_i <= num_i[MW-1];
      mag_r <= num_r[MW-1] ? MW'(-num_r) : MW'(num_r);
      mag_i <= num_i[MW-1] ? MW'(-num_i) : MW'(num_i);
      den_b <= PW'($unsigned(p_bb_r)) + PW'($unsigned(p_bb_i));
      sb_r  <= s_r;
      sb_i  <= s_i;
    end
  end

  // quotient too wide for the format is caught before the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c.valid <= 1'b0;
    end else if (adv) begin
      ctl_c.valid <= ctl_b.valid;
    end
    if (adv) begin
      ctl_c.op   <= ctl_b.op;
      ctl_c.eq   <= ctl_b.eq;
      ctl_c.div0 <= ctl_b.div0;
      rem_r <= XW'(mag_r) << FRAC_BITS;
      rem_i <= XW'(mag_i) << FRAC_BITS;
      den   <= den_b;
      pass  <= {sb_i, sb_r, mag_i >> FRAC_BITS, mag_r >> FRAC_BITS, neg_i, neg_r,
                ((XW'(mag_i) << FRAC_BITS) >= (XW'(den_b) << W)),
                ((XW'(mag_r) << FRAC_BITS) >= (XW'(den_b) << W))};
    end
  end

  assign ctl_o = ctl_c;

endmodule

// File: hw/rtl/cau_div_stage.sv
// ----------------------------------------------------------------------------
// cau_div_stage
// one restoring division step for both parts, one quotient bit
// ----------------------------------------------------------------------------
module cau_div_stage #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int XW         = 3 * DATA_WIDTH + 1,
  parameter int PASS_W     = 1,
  parameter int SHIFT      = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  cau_pkg::ctl_t           ctl_i,
  input  logic [XW-1:0]           rem_r_i,
  input  logic [XW-1:0]           rem_i_i,
  input  logic [DATA_WIDTH-1:0]   q_r_i,
  input  logic [DATA_WIDTH-1:0]   q_i_i,
  input  logic [2*DATA_WIDTH-1:0] den_i,
  input  logic [PASS_W-1:0]       pass_i,
  output cau_pkg::ctl_t           ctl_o,
  output logic [XW-1:0]           rem_r_o,
  output logic [XW-1:0]           rem_i_o,
  output logic [DATA_WIDTH-1:0]   q_r_o,
  output logic [DATA_WIDTH-1:0]   q_i_o,
  output logic [2*DATA_WIDTH-1:0] den_o,
  output logic [PASS_W-1:0]       pass_o
);
  import cau_pkg::*;

  logic [XW-1:0] trial;
  logic          ge_r, ge_i;

  assign trial = XW'(den_i) << SHIFT;
  assign ge_r  = rem_r_i >= trial;
  assign ge_i  = rem_i_i >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else if (adv) begin
      ctl_o.valid <= ctl_i.valid;
    end
    if (adv) begin
      ctl_o.op   <= ctl_i.op;
      ctl_o.eq   <= ctl_i.eq;
      ctl_o.div0 <= ctl_i.div0;
      rem_r_o <= ge_r ? rem_r_i - trial : rem_r_i;
      rem_i_o <= ge_i ? rem_i_i - trial : rem_i_i;
      q_r_o   <= q_r_i | (DATA_WIDTH'(ge_r) << SHIFT);
      q_i_o   <= q_i_i | (DATA_WIDTH'(ge_i) << SHIFT);
      den_o   <= den_i;
      pass_o  <= pass_i;
    end
  end

endmodule

// File: hw/rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// result selection, saturation and status, output register
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int PASS_W     = 4 + 2 * (2 * DATA_WIDTH + 1) + 2 * (DATA_WIDTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  cau_pkg::ctl_t         ctl_i,
  input  logic [DATA_WIDTH-1:0] q_r,
  input  logic [DATA_WIDTH-1:0] q_i,
  input  logic [PASS_W-1:0]     pass_i,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] res_real,
  output logic [DATA_WIDTH-1:0] res_imag,
  output logic                  is_equal,
  output logic [1:0]            status
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int MW = 2 * W + 1;
  localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);
  localparam logic [MW-1:0] BIG = MW'(1) << W;

  // returns {flag, value}
  function automatic logic [W:0] sat_sm(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] m;
    if (neg) begin
      if (mag > LIM) begin
        return {1'b1, LIM[W-1:0]};
      end
      m = -mag;
      return {1'b0, m[W-1:0]};
    end
    if (mag > LIM - MW'(1)) begin
      m = LIM - MW'(1);
      return {1'b1, m[W-1:0]};
    end
    return {1'b0, mag[W-1:0]};
  endfunction

  logic              ovf_r, ovf_i, neg_r, neg_i;
  logic [MW-1:0]     mul_r, mul_i, sx_r, sx_i;
  logic signed [W:0] s_r, s_i;
  logic [W:0]        o_r, o_i;
  logic [W-1:0]      res_real_next, res_imag_next;
  logic              eq_next;
  logic [1:0]        status_next;

  assign {s_i, s_r, mul_i, mul_r, neg_i, neg_r, ovf_i, ovf_r} = pass_i;
  assign sx_r = MW'(s_r);
  assign sx_i = MW'(s_i);

  always_comb begin
    o_r           = '0;
    o_i           = '0;
    eq_next       = 1'b0;
    case (ctl_i.op)
      OP_ADD, OP_SUB, OP_CONJ: begin
        o_r = sat_sm(s_r[W], s_r[W] ? -sx_r : sx_r);
        o_i = sat_sm(s_i[W], s_i[W] ? -sx_i : sx_i);
      end
      OP_MUL: begin
        o_r = sat_sm(neg_r, mul_r);
        o_i = sat_sm(neg_i, mul_i);
      end
      OP_DIV: begin
        if (!ctl_i.div0) begin
          o_r = sat_sm(neg_r, ovf_r ? BIG : MW'(q_r));
          o_i = sat_sm(neg_i, ovf_i ? BIG : MW'(q_i));
        end
      end
      OP_CMP: begin
        eq_next = ctl_i.eq;
      end
      default: begin
        eq_next = 1'b0;
      end
    endcase
    res_real_next = o_r[W-1:0];
    res_imag_next = o_i[W-1:0];
    if (ctl_i.div0) begin
      status_next = ST_DIV0;
    end else if (o_r[W] || o_i[W]) begin
      status_next = ST_SAT;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_i.valid;
    end
    if (adv) begin
      res_real <= res_real_next;
      res_imag <= res_imag_next;
      is_equal <= eq_next;
      status   <= status_next;
    end
  end

endmodule

// File: hw/rtl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// pipelined complex fixed-point alu
// ----------------------------------------------------------------------------
// takes one word per cycle unless the output stalls and gives one result
// word per input word, in order. the divider retires one quotient bit per
// stage across DATA_WIDTH stages; every operation runs through the same
// stages so results never reorder. a stall on the output freezes the whole
// pipeline, with the output register acting as the final stage, so no word
// is lost or repeated. products and quotients are truncated toward zero,
// any part that leaves the signed range saturates with status 1, and divide
// by zero gives zero parts with status 2
module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // a_real, a_imag, b_real, b_imag from bit 0 up, zero padded to bytes
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
  // req_type
  input  logic [2:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // res_real, res_imag from bit 0 up, zero padded to bytes
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
  // is_equal, status from bit 0 up
  output logic [2:0]                             m_tuser
);
  import cau_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int XW     = 3 * W + FRAC_BITS + 1;
  localparam int PASS_W = 4 + 2 * (2 * W + 1) + 2 * (W + 1);
  localparam int OTDW   = ((2 * W + 7) / 8) * 8;

  logic adv;

  // divider chain, index 0 is the set-up stage output
  ctl_t            ctl    [W+1];
  logic [XW-1:0]   rem_r  [W+1];
  logic [XW-1:0]   rem_i  [W+1];
  logic [W-1:0]    q_r    [W+1];
  logic [W-1:0]    q_i    [W+1];
  logic [2*W-1:0]  den    [W+1];
  logic [PASS_W-1:0] pass [W+1];

  logic [W-1:0] res_real, res_imag;
  logic         is_equal;
  logic [1:0]   status;

  // the pipeline moves whenever the output register is empty or being read
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  cau_front #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .XW         (XW),
    .PASS_W     (PASS_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .a_real   (s_tdata[W-1:0]),
    .a_imag   (s_tdata[2*W-1:W]),
    .b_real   (s_tdata[3*W-1:2*W]),
    .b_imag   (s_tdata[4*W-1:3*W]),
    .ctl_o    (ctl[0]),
    .rem_r    (rem_r[0]),
    .rem_i    (rem_i[0]),
    .den      (den[0]),
    .pass     (pass[0])
  );

  assign q_r[0] = '0;
  assign q_i[0] = '0;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < W; k++) begin : g_div
    cau_div_stage #(
      .DATA_WIDTH (W),
      .XW         (XW),
      .PASS_W     (PASS_W),
      .SHIFT      (W - 1 - k)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_i   (ctl[k]),
      .rem_r_i (rem_r[k]),
      .rem_i_i (rem_i[k]),
      .q_r_i   (q_r[k]),
      .q_i_i   (q_i[k]),
      .den_i   (den[k]),
      .pass_i  (pass[k]),
      .ctl_o   (ctl[k+1]),
      .rem_r_o (rem_r[k+1]),
      .rem_i_o (rem_i[k+1]),
      .q_r_o   (q_r[k+1]),
      .q_i_o   (q_i[k+1]),
      .den_o   (den[k+1]),
      .pass_o  (pass[k+1])
    );
  end

  cau_back #(
    .DATA_WIDTH (W),
    .PASS_W     (PASS_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_i     (ctl[W]),
    .q_r       (q_r[W]),
    .q_i       (q_i[W]),
    .pass_i    (pass[W]),
    .out_valid (m_tvalid),
    .res_real  (res_real),
    .res_imag  (res_imag),
    .is_equal  (is_equal),
    .status    (status)
  );

  assign m_tdata = OTDW'({res_imag, res_real});
  assign m_tuser = {status, is_equal};

endmodule
